>>> rtl/b36_pkg.sv
`default_nettype none

package b36_pkg;

  // base and digit count of a 64-bit value
  localparam int unsigned RADIX      = 36;
  localparam int unsigned MAX_DIGITS = 13;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned IDX_W      = 4;

  // long division by the radix, one chunk per cycle
  localparam int unsigned CHUNK_W    = 16;
  localparam int unsigned NUM_CHUNKS = VALUE_W / CHUNK_W;
  localparam int unsigned STEP_W     = 2;
  localparam int unsigned NUMER_W    = DIGIT_W + CHUNK_W;
  localparam int unsigned HALF_W     = NUMER_W - 2;

  // n/36 = (n>>2)/9, and m/9 = (m * RECIP9) >> RECIP_SHIFT, exact for m < 2^21
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP9 = 20'd932068;
  localparam int unsigned PROD_W      = HALF_W + RECIP_W;

  localparam logic [CHAR_W-1:0] ASCII_DIGIT_OFS  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_LETTER_OFS = 7'd55;
  localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT   = 6'd10;

  localparam logic [IDX_W-1:0] LAST_SLOT = 4'(MAX_DIGITS - 1);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // stack control from the sequencer
  typedef struct packed {
    logic   wr_en;
    idx_t   wr_idx;
    digit_t wr_digit;
    idx_t   rd_idx;
  } stack_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input digit_t d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DECIMAL_LIMIT) begin
      return dx + ASCII_DIGIT_OFS;
    end
    return dx + ASCII_LETTER_OFS;
  endfunction

endpackage

`default_nettype wire

>>> rtl/b36_if.sv
`default_nettype none

interface b36_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface b36_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

>>> rtl/b36_div_step.sv
`default_nettype none

module b36_div_step (
  input  wire logic [b36_pkg::DIGIT_W-1:0] part_in,
  input  wire logic [b36_pkg::CHUNK_W-1:0] chunk_in,
  output logic      [b36_pkg::CHUNK_W-1:0] quot_out,
  output logic      [b36_pkg::DIGIT_W-1:0] part_out
);

  logic [b36_pkg::NUMER_W-1:0] numer;
  logic [b36_pkg::HALF_W-1:0]  half;
  logic [b36_pkg::PROD_W-1:0]  prod;
  logic [b36_pkg::NUMER_W-1:0] back;
  logic [b36_pkg::NUMER_W-1:0] diff;

  // part_in < 36, so the quotient fits one chunk
  assign numer    = {part_in, chunk_in};
  assign half     = numer[b36_pkg::NUMER_W-1:2];
  assign prod     = b36_pkg::PROD_W'(half) * b36_pkg::PROD_W'(b36_pkg::RECIP9);
  assign quot_out = prod[b36_pkg::RECIP_SHIFT +: b36_pkg::CHUNK_W];

  // q*36 = q*32 + q*4
  assign back     = (b36_pkg::NUMER_W'(quot_out) << 5) + (b36_pkg::NUMER_W'(quot_out) << 2);
  assign diff     = numer - back;
  assign part_out = diff[b36_pkg::DIGIT_W-1:0];

endmodule

`default_nettype wire

>>> rtl/b36_digit_stack.sv
`default_nettype none

module b36_digit_stack (
  input  wire logic                clk,
  input  wire b36_pkg::stack_ctl_t ctl,
  output b36_pkg::digit_t          rd_digit
);

  b36_pkg::digit_t slot_r [b36_pkg::MAX_DIGITS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      slot_r[ctl.wr_idx] <= ctl.wr_digit;
    end
  end

  assign rd_digit = slot_r[ctl.rd_idx];

endmodule

`default_nettype wire

>>> rtl/binary_to_base36_ascii.sv
`default_nettype none

// a value of d base-36 digits (1..13) is first divided digit by digit, then its digits are sent,
// one digit per cycle while out_chan.ready is high
// a new value is taken only in idle, once the last digit of the previous value has been sent;
// the shared divide-by-36 unit takes one 16-bit chunk per cycle, four chunks per digit
// reset: synchronous, active low; returns to idle and drops out_chan.valid
module binary_to_base36_ascii (
  input  wire logic  clk,
  input  wire logic  rst_n,
  b36_in_if.sink     in_chan,
  b36_out_if.source  out_chan
);

  // sequencer state
  b36_pkg::state_t state_r, state_nxt;

  // value being divided; quotient chunks shift in from the bottom
  logic [b36_pkg::VALUE_W-1:0] work_r, work_nxt;
  // partial remainder carried from chunk to chunk, ends as the digit
  b36_pkg::digit_t             part_r, part_nxt;
  // chunk counter within one digit
  logic [b36_pkg::STEP_W-1:0]  step_r, step_nxt;
  // digits found so far; then the slot being sent
  b36_pkg::idx_t               cnt_r, cnt_nxt;
  b36_pkg::idx_t               idx_r, idx_nxt;

  logic [b36_pkg::CHUNK_W-1:0] quot;
  b36_pkg::digit_t             part_new;
  logic [b36_pkg::VALUE_W-1:0] work_shifted;
  logic                        last_step;
  logic                        stack_full;
  b36_pkg::stack_ctl_t         stack_ctl;
  b36_pkg::digit_t             top_digit;
  logic                        in_fire;
  logic                        out_fire;

  // shared divide unit, fed with the top chunk of the working value
  b36_div_step u_div (
    .part_in  (part_r),
    .chunk_in (work_r[b36_pkg::VALUE_W-1 -: b36_pkg::CHUNK_W]),
    .quot_out (quot),
    .part_out (part_new)
  );

  // digits are found least significant first and sent back out in reverse
  b36_digit_stack u_stack (
    .clk      (clk),
    .ctl      (stack_ctl),
    .rd_digit (top_digit)
  );

  assign work_shifted = {work_r[b36_pkg::VALUE_W-b36_pkg::CHUNK_W-1:0], quot};
  assign last_step    = (step_r == b36_pkg::STEP_W'(b36_pkg::NUM_CHUNKS - 1));
  assign stack_full   = (cnt_r == b36_pkg::LAST_SLOT);

  assign in_chan.ready = (state_r == b36_pkg::ST_IDLE);
  assign in_fire       = in_chan.valid & in_chan.ready;

  assign out_chan.valid      = (state_r == b36_pkg::ST_EMIT);
  assign out_chan.digit_char = b36_pkg::digit_to_ascii(top_digit);
  assign out_chan.last_digit = (idx_r == '0);
  assign out_fire            = out_chan.valid & out_chan.ready;

  always_comb begin
    stack_ctl.wr_en    = (state_r == b36_pkg::ST_DIV) & last_step;
    stack_ctl.wr_idx   = cnt_r;
    stack_ctl.wr_digit = part_new;
    stack_ctl.rd_idx   = idx_r;
  end

  always_comb begin
    state_nxt = state_r;
    work_nxt  = work_r;
    part_nxt  = part_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      b36_pkg::ST_IDLE: begin
        if (in_fire) begin
          work_nxt  = in_chan.value;
          part_nxt  = '0;
          step_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = b36_pkg::ST_DIV;
        end
      end
      b36_pkg::ST_DIV: begin
        work_nxt = work_shifted;
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          // digit done: restart the remainder for the next one
          part_nxt = '0;
          cnt_nxt  = cnt_r + 1'b1;
          // a zero quotient or a full stack ends the value
          if ((work_shifted == '0) || stack_full) begin
            idx_nxt   = cnt_r;
            state_nxt = b36_pkg::ST_EMIT;
          end
        end else begin
          part_nxt = part_new;
        end
      end
      b36_pkg::ST_EMIT: begin
        if (out_fire) begin
          if (idx_r == '0) begin
            state_nxt = b36_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = b36_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b36_pkg::ST_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    part_r <= part_nxt;
  end

endmodule

`default_nettype wire
